FILE: hdl/mm3_pkg.sv
package mm3_pkg;

  // Scramble, update and finalization constants of the 32-bit hash.
  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

  // Byte count of a whole word.
  localparam logic [2:0] FULL_COUNT = 3'd4;

  // Constant that the shared multiplier applies.
  typedef enum logic [1:0] {
    MUL_MIX_C1 = 2'd0,
    MUL_MIX_C2 = 2'd1,
    MUL_FIN_C1 = 2'd2,
    MUL_FIN_C2 = 2'd3
  } mul_sel_t;

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL2 = 6'b000010,
    S_MIX  = 6'b000100,
    S_FIN1 = 6'b001000,
    S_FIN2 = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

FILE: hdl/mm3_mult.sv
module mm3_mult import mm3_pkg::*; (
  input  logic [31:0] op_a,
  input  mul_sel_t    sel,
  output logic [31:0] product
);

  logic [31:0] op_b;

  // Pick the constant for this step.
  always_comb begin
    case (sel)
      MUL_MIX_C1: op_b = MIX_C1;
      MUL_MIX_C2: op_b = MIX_C2;
      MUL_FIN_C1: op_b = FIN_C1;
      MUL_FIN_C2: op_b = FIN_C2;
      default:    op_b = MIX_C1;
    endcase
  end

  // Only the low 32 bits of the product are kept.
  assign product = op_a * op_b;

endmodule

FILE: hdl/murmur3_hash_32.sv
// 32-bit MurmurHash3 engine for messages that arrive as little-endian words.
//
// Input channel (in_valid/in_ready): one word per transfer, first byte in
// bits 7..0. in_last_word marks the final word; only then is in_byte_count
// looked at (0 to 4, larger values count as 4). Other words count as 4 bytes.
// Result channel (out_valid/out_ready): one hash per message, after its last
// word. Configuration channel (cfg_valid/cfg_ready): writes the seed, which
// is loaded when the first word of the next message is taken.
//
// One multiplier is shared by all multiply steps, so a word that is not last
// goes through accept with the first scramble multiply, second multiply and
// hash update before the next word is taken. A last word adds three more steps
// (two finalization multiplies, then the finishing step) for its hash.
// The output register is separate from the sequencer; a stalled receiver
// holds only the finishing step of the next message, not the word steps.
// Synchronous reset clears the seed to zero, drops out_valid and starts a
// new message.
module murmur3_hash_32 import mm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed
);

  state_t      state_r, state_nxt;
  logic [31:0] seed_r;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] k_r, k_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;
  logic        start_r, start_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic        in_fire;
  logic        out_free;
  logic [2:0]  in_cnt;
  logic [31:0] in_masked;
  logic [31:0] mul_a;
  mul_sel_t    mul_sel;
  logic [31:0] mul_p;
  logic [31:0] mixed;
  logic [31:0] fin_x;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // Effective byte count and tail masking of the incoming word.
  always_comb begin
    if (!in_last_word || in_byte_count > FULL_COUNT) begin
      in_cnt = FULL_COUNT;
    end else begin
      in_cnt = in_byte_count;
    end
    case (in_cnt)
      3'd0:    in_masked = 32'h0;
      3'd1:    in_masked = {24'h0, in_data_word[7:0]};
      3'd2:    in_masked = {16'h0, in_data_word[15:0]};
      3'd3:    in_masked = {8'h0, in_data_word[23:0]};
      default: in_masked = in_data_word;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    fin_x = hash_r ^ total_r;
    case (state_r)
      S_MUL2: begin
        mul_a   = rotl(k_r, 15);
        mul_sel = MUL_MIX_C2;
      end
      S_FIN1: begin
        mul_a   = fin_x ^ (fin_x >> 16);
        mul_sel = MUL_FIN_C1;
      end
      S_FIN2: begin
        mul_a   = k_r ^ (k_r >> 13);
        mul_sel = MUL_FIN_C2;
      end
      default: begin
        mul_a   = in_masked;
        mul_sel = MUL_MIX_C1;
      end
    endcase
  end

  mm3_mult u_mult (
    .op_a    (mul_a),
    .sel     (mul_sel),
    .product (mul_p)
  );

  // Running hash after the scrambled word is folded in.
  assign mixed = hash_r ^ k_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    total_nxt     = total_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hash_nxt  = out_hash_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          k_nxt     = mul_p;
          cnt_nxt   = in_cnt;
          last_nxt  = in_last_word;
          start_nxt = in_last_word;
          if (start_r) begin
            hash_nxt  = seed_r;
            total_nxt = 32'h0;
          end
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        k_nxt     = mul_p;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        if (cnt_r == FULL_COUNT) begin
          hash_nxt = (rotl(mixed, 13) << 2) + rotl(mixed, 13) + MIX_ADD;
        end else begin
          hash_nxt = mixed;
        end
        total_nxt = total_r + {29'h0, cnt_r};
        state_nxt = last_r ? S_FIN1 : S_IDLE;
      end
      S_FIN1: begin
        k_nxt     = mul_p;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        k_nxt     = mul_p;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = k_r ^ (k_r >> 16);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= 32'h0;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
      hash_r      <= 32'h0;
      total_r     <= 32'h0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      hash_r      <= hash_nxt;
      total_r     <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_seed;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

  // The sequencer is always in exactly one state.
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state is not one-hot");

  // A word that is not last returns to idle right after its update step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX && !last_r) |=> (state_r == S_IDLE))
    else $error("non-final word did not return to idle");

  // A result appears only from the finishing step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the finishing step");

  // The finishing step holds, and no input is taken, while the output is blocked.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_free) |=> (state_r == S_OUT && !in_ready))
    else $error("finishing step left while output is blocked");

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Hash constants, kept separate from the design's own copies.
  localparam logic [31:0] SCR_MUL_A  = 32'hcc9e2d51;
  localparam logic [31:0] SCR_MUL_B  = 32'h1b873593;
  localparam logic [31:0] HASH_ADD   = 32'he6546b64;
  localparam logic [31:0] FMIX_MUL_A = 32'h85ebca6b;
  localparam logic [31:0] FMIX_MUL_B = 32'hc2b2ae35;
  localparam logic [2:0]  WORD_BYTES = 3'd4;

  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;

  // Running hash of the current message and the queue of finished hashes.
  class hash_scoreboard;
    logic [31:0] seed_value = '0;
    logic [31:0] run_hash   = '0;
    logic [31:0] byte_total = '0;
    bit          in_message = 1'b0;
    logic [31:0] pending_hashes[$];
    int          errors = 0;
    int          words_seen = 0;
    int          messages_seen = 0;
    int          hashes_checked = 0;

    function logic [31:0] rotate_left(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function logic [31:0] scramble(logic [31:0] k);
      k = k * SCR_MUL_A;
      k = rotate_left(k, 15);
      return k * SCR_MUL_B;
    endfunction

    function logic [31:0] finalize(logic [31:0] h);
      h = h ^ (h >> 16);
      h = h * FMIX_MUL_A;
      h = h ^ (h >> 13);
      h = h * FMIX_MUL_B;
      return h ^ (h >> 16);
    endfunction

    function void absorb_word(logic [31:0] w);
      run_hash   = rotate_left(run_hash ^ scramble(w), 13);
      run_hash   = run_hash * 5 + HASH_ADD;
      byte_total = byte_total + WORD_BYTES;
    endfunction

    function void load_seed(logic [31:0] s);
      seed_value = s;
    endfunction

    // Called for every accepted input word.
    function void note_word(logic [31:0] w, logic [2:0] cnt, logic last);
      logic [2:0]  n;
      logic [31:0] mask;
      if (!in_message) begin
        run_hash   = seed_value;
        byte_total = '0;
        in_message = 1'b1;
      end
      words_seen++;
      if (!last) begin
        absorb_word(w);
        return;
      end
      n = (cnt > WORD_BYTES) ? WORD_BYTES : cnt;
      if (n == WORD_BYTES) begin
        absorb_word(w);
      end else if (n != 0) begin
        mask       = (32'h1 << (8 * n)) - 32'h1;
        run_hash   = run_hash ^ scramble(w & mask);
        byte_total = byte_total + n;
      end
      pending_hashes.push_back(finalize(run_hash ^ byte_total));
      in_message = 1'b0;
      messages_seen++;
    endfunction

    // Called for every accepted output hash.
    function void check_hash(logic [31:0] got);
      logic [31:0] want;
      if (pending_hashes.size() == 0) begin
        $display("%0t: hash %h arrived with none expected", $time, got);
        errors++;
        return;
      end
      want = pending_hashes.pop_front();
      hashes_checked++;
      if (got !== want) begin
        $display("%0t: hash mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction

    function void close_out();
      if (pending_hashes.size() != 0) begin
        $display("%0t: %0d expected hashes never arrived", $time, pending_hashes.size());
        errors += pending_hashes.size();
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_data_word;
  logic [2:0]  in_byte_count;
  logic        in_last_word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_hash_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_seed;

  hash_scoreboard sb = new;
  bit calm = 1'b0;
  bit rush = 1'b0;
  bit hold_off = 1'b0;
  int seeds_used = 0;

  murmur3_hash_32 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_seed       (cfg_seed)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word and hold it until the transfer; then maybe idle a while.
  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic last);
    in_valid      <= 1'b1;
    in_data_word  <= w;
    in_byte_count <= cnt;
    in_last_word  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w, cnt, last);
    if (!calm && !rush && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // A message of random words; the count field of inner words is random too.
  task automatic send_message(input int n_words, input logic [2:0] tail);
    logic [2:0] cnt;
    for (int i = 0; i < n_words; i++) begin
      cnt = 3'($urandom_range(0, 7));
      if (i == n_words - 1) begin
        send_word($urandom, tail, 1'b1);
      end else begin
        send_word($urandom, cnt, 1'b0);
      end
    end
  endtask

  // Random messages, mostly short, with partial and oversized tail counts.
  task automatic run_messages(input int n_items, input bit short_only);
    int         sent;
    int         len;
    int         r;
    logic [2:0] tail;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (short_only) len = $urandom_range(1, 2);
      else if (r < 6) len = $urandom_range(1, 4);
      else if (r < 9) len = $urandom_range(5, 12);
      else len = $urandom_range(13, 40);
      r = $urandom_range(0, 19);
      tail = 3'((r < 16) ? r % 5 : 5 + r % 3);
      send_message(len, tail);
      sent += len;
    end
  endtask

  // Stop offering words and wait until every expected hash has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_hashes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] s);
    cfg_valid <= 1'b1;
    cfg_seed  <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.load_seed(s);
    seeds_used++;
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Check every hash transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_hash(out_hash_value);
  end

  // Watchdog: end the run if no transfer happens on any channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_word  = '0;
    in_byte_count = '0;
    in_last_word  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_seed      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset seed: empty tail, full and partial tails,
    // bytes above the count, oversized counts, and ignored counts on inner words.
    send_word(32'h9e3779b9, 3'd0, 1'b1);
    send_word(32'hffffffff, WORD_BYTES, 1'b1);
    send_word(32'h00000000, WORD_BYTES, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd3, 1'b1);
    send_word(32'hdeadbeef, 3'd5, 1'b1);
    send_word(32'hdeadbeef, 3'd6, 1'b1);
    send_word(32'hdeadbeef, 3'd7, 1'b1);
    send_word(32'hffffffff, 3'd0, 1'b0);
    send_word(32'h00000000, 3'd7, 1'b0);
    send_word(32'h12345678, 3'd2, 1'b1);
    send_word(32'h89abcdef, 3'd3, 1'b0);
    send_word(32'hffffffff, WORD_BYTES, 1'b0);
    send_word(32'h5a5aa5a5, 3'd0, 1'b1);

    // A seed written inside a message applies only to the next one.
    send_word(32'hcafef00d, WORD_BYTES, 1'b0);
    wait_drained();
    write_seed(32'hffffffff);
    send_word(32'h0000ffff, 3'd3, 1'b1);
    send_word(32'h76543210, WORD_BYTES, 1'b1);
    wait_drained();

    write_seed($urandom);
    run_messages(250, 1'b0);
    wait_drained();

    // Long result hold-off while short messages keep coming, so the input stalls.
    write_seed(32'h00000000);
    hold_off = 1'b1;
    rush     = 1'b1;
    run_messages(60, 1'b1);
    rush = 1'b0;
    wait_drained();

    // Sender pauses in the middle of this phase until all hashes are back.
    write_seed(32'h80000000);
    run_messages(120, 1'b0);
    wait_drained();
    run_messages(130, 1'b0);
    wait_drained();

    write_seed($urandom);
    run_messages(300, 1'b0);
    wait_drained();

    // Closing stretch with no idling on either side.
    calm = 1'b1;
    write_seed(32'h00000001);
    run_messages(300, 1'b0);
    wait_drained();

    sb.close_out();
    $display("Hashed %0d words in %0d messages under %0d seed settings.",
             sb.words_seen, sb.messages_seen, seeds_used + 1);
    $display("Compared %0d hashes, with random stalls and one long output hold-off.",
             sb.hashes_checked);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
